[sv/char_lcd_write_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the character display write sequencer
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH

// Clocked check, off while reset is asserted.
`define CLW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
  else $error(msg);

// Clocked check that also holds during reset.
`define CLW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/clw_pkg.sv]
// ----------------------------------------------------------------------------
// clw_pkg
// Types and constants shared by the display write sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package clw_pkg;

  typedef enum logic [1:0] {
    ACT_INIT   = 2'd0,
    ACT_PUT    = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_STRING = 2'd3
  } clw_action_e;

  localparam logic [7:0] NibbleMask  = 8'h0f;
  localparam logic [7:0] CmdWake     = 8'h03 & NibbleMask;
  localparam logic [7:0] CmdFourBit  = 8'h02 & NibbleMask;
  localparam logic [7:0] CmdFunction = 8'h28;
  localparam logic [7:0] CmdDispOn   = 8'h0c;
  localparam logic [7:0] CmdEntry    = 8'h06;
  localparam logic [7:0] SpaceCode   = 8'h20;

  localparam logic [7:0] Line1Reset = 8'd128;
  localparam logic [7:0] Line2Reset = 8'd192;
  localparam logic [7:0] Line3Reset = 8'd148;
  localparam logic [7:0] Line4Reset = 8'd212;

  // last step of the init run (seven bytes)
  localparam logic [2:0] InitLastStep = 3'd6;

  // work item handed from front to back
  typedef struct packed {
    clw_action_e action;
    logic [7:0]  addr;       // set-address command (line base, plus column)
    logic [7:0]  data;
    logic        send_addr;
    logic        send_data;
  } clw_desc_t;

  typedef struct packed {
    logic [7:0] code;
    logic       nib;
  } clw_byte_t;

  function automatic clw_byte_t clw_init_byte(input logic [2:0] step);
    clw_byte_t b;
    case (step) inside
      3'd0, 3'd1, 3'd2: b = '{code: CmdWake,     nib: 1'b1};
      3'd3:             b = '{code: CmdFourBit,  nib: 1'b1};
      3'd4:             b = '{code: CmdFunction, nib: 1'b0};
      3'd5:             b = '{code: CmdDispOn,   nib: 1'b0};
      default:          b = '{code: CmdEntry,    nib: 1'b0};
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[sv/clw_front.sv]
// ----------------------------------------------------------------------------
// clw_front
// Holds the line address registers, takes requests and turns each into a
// work item; requests that cause no bytes are consumed here.
// ----------------------------------------------------------------------------
`default_nettype none

module clw_front import clw_pkg::*; #(
  parameter int LINE_LENGTH = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [1:0]  line_select_i,
  input  wire logic [4:0]  column_i,
  input  wire logic [5:0]  string_offset_i,
  input  wire logic [7:0]  char_code_i,
  output logic             push_valid_o,
  input  wire logic        push_ready_i,
  output clw_desc_t        push_desc_o
);

  localparam logic [5:0] LineLen = 6'(LINE_LENGTH);
  localparam logic [4:0] LastCol = 5'(LINE_LENGTH - 1);
  localparam logic [6:0] SpanLen = 7'(LINE_LENGTH);

  logic [7:0] line_base_q [4];
  logic [7:0] base;
  logic [4:0] col_clamped;
  logic [6:0] span;
  clw_desc_t  desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_base_q[0] <= Line1Reset;
      line_base_q[1] <= Line2Reset;
      line_base_q[2] <= Line3Reset;
      line_base_q[3] <= Line4Reset;
    end else if (cfg_we_i) begin
      line_base_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_comb begin
    base        = line_base_q[line_select_i];
    col_clamped = ({1'b0, column_i} >= LineLen) ? LastCol : column_i;
    span        = {2'b00, column_i} + {1'b0, string_offset_i};

    desc           = '0;
    desc.action    = clw_action_e'(action_i);
    desc.addr      = base;
    desc.data      = char_code_i;
    desc.send_addr = 1'b1;
    desc.send_data = 1'b1;
    unique case (desc.action)
      ACT_PUT: begin
        desc.addr = base + {3'b000, col_clamped};
      end
      ACT_STRING: begin
        // unclamped start; a start past the line end only fails the fit test
        desc.addr      = base + {3'b000, column_i};
        desc.send_addr = (string_offset_i == '0);
        desc.send_data = (span < SpanLen);
      end
      ACT_INIT, ACT_CLEAR: begin
      end
    endcase
  end

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i & (desc.send_addr | desc.send_data);
  assign push_desc_o  = desc;

endmodule

`default_nettype wire

[sv/clw_queue.sv]
// ----------------------------------------------------------------------------
// clw_queue
// Two-entry queue of work items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module clw_queue import clw_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_valid_i,
  output logic            push_ready_o,
  input  clw_desc_t       push_desc_i,
  output logic            pop_valid_o,
  input  wire logic       pop_ready_i,
  output clw_desc_t       pop_desc_o
);

  clw_desc_t  entry_q [2];
  logic [1:0] count_q, count_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_desc_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    count_d = count_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_desc_i;
  end

endmodule

`default_nettype wire

[sv/clw_back.sv]
// ----------------------------------------------------------------------------
// clw_back
// Expands one work item at a time into its byte run, one byte per cycle
// while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module clw_back import clw_pkg::*; #(
  parameter int LINE_LENGTH = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        pop_valid_i,
  output logic             pop_ready_o,
  input  clw_desc_t        pop_desc_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             register_select_o,
  output logic [7:0]       code_byte_o,
  output logic             nibble_only_o,
  output logic             last_of_run_o
);

  localparam int ClrSteps = 2 * LINE_LENGTH;
  localparam int StepW    = (ClrSteps > 8) ? $clog2(ClrSteps) : 3;
  localparam logic [StepW-1:0] ClrLast = StepW'(ClrSteps - 1);

  logic             busy_q;
  logic [StepW-1:0] step_q;
  clw_desc_t        desc_q;
  logic             out_valid_q;
  logic             rs_q, nib_q, last_q;
  logic [7:0]       code_q;

  logic             advance, emit, load;
  logic             gen_rs, gen_nib, gen_last;
  logic [7:0]       gen_code;
  clw_byte_t        init_byte;
  logic [StepW-1:0] first_step;

  assign advance     = ~out_valid_q | out_ready_i;
  assign emit        = busy_q & advance;
  // next item may load in the cycle the current one sends its last byte
  assign pop_ready_o = ~busy_q | (emit & gen_last);
  assign load        = pop_valid_i & pop_ready_o;
  // a string char without address starts at the data step
  assign first_step  = (pop_desc_i.action == ACT_STRING && !pop_desc_i.send_addr)
                       ? StepW'(1) : '0;

  always_comb begin
    init_byte = clw_init_byte(step_q[2:0]);
    gen_rs    = 1'b0;
    gen_nib   = 1'b0;
    gen_code  = desc_q.addr;
    gen_last  = 1'b0;
    unique case (desc_q.action) inside
      ACT_INIT: begin
        gen_code = init_byte.code;
        gen_nib  = init_byte.nib;
        gen_last = (step_q[2:0] == InitLastStep);
      end
      ACT_CLEAR: begin
        if (step_q[0]) begin
          gen_rs   = 1'b1;
          gen_code = SpaceCode;
        end else begin
          gen_code = desc_q.addr + 8'(step_q >> 1);
        end
        gen_last = (step_q == ClrLast);
      end
      ACT_PUT, ACT_STRING: begin
        if (step_q[0]) begin
          gen_rs   = 1'b1;
          gen_code = desc_q.data;
          gen_last = 1'b1;
        end else begin
          gen_last = ~desc_q.send_data;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      desc_q      <= '0;
    end else begin
      if (advance) out_valid_q <= busy_q;
      if (load) begin
        busy_q <= 1'b1;
        step_q <= first_step;
        desc_q <= pop_desc_i;
      end else if (emit) begin
        busy_q <= ~gen_last;
        step_q <= step_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rs_q   <= gen_rs;
      code_q <= gen_code;
      nib_q  <= gen_nib;
      last_q <= gen_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign register_select_o = rs_q;
  assign code_byte_o       = code_q;
  assign nibble_only_o     = nib_q;
  assign last_of_run_o     = last_q;

endmodule

`default_nettype wire

[sv/char_lcd_write_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// Turns character display requests into tagged bytes for a 4-bit panel.
// ----------------------------------------------------------------------------
// The front takes one request per cycle while its two-entry queue has room;
// requests that cause no bytes (a dropped string character) are consumed at
// once. The back sends one byte per cycle when the output is not stalled; a
// request's run has 7 bytes for init, 2 for put_char, 1 or 2 for string_char
// and 2*LINE_LENGTH for clear_line. The next request is loaded in the cycle
// the last byte is registered, so runs follow without a gap. Line addresses
// reset to 0x80, 0xc0, 0x94 and 0xd4; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_write_sequencer import clw_pkg::*; #(
  parameter int LINE_LENGTH = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [1:0]  line_select_i,
  input  wire logic [4:0]  column_i,
  input  wire logic [5:0]  string_offset_i,
  input  wire logic [7:0]  char_code_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             register_select_o,
  output logic [7:0]       code_byte_o,
  output logic             nibble_only_o,
  output logic             last_of_run_o
);

  logic      push_valid, push_ready, pop_valid, pop_ready;
  clw_desc_t push_desc, pop_desc;

  clw_front #(.LINE_LENGTH(LINE_LENGTH)) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .action_i,
    .line_select_i,
    .column_i,
    .string_offset_i,
    .char_code_i,
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_desc_o  (push_desc)
  );

  clw_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_desc_i  (push_desc),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_desc_o   (pop_desc)
  );

  clw_back #(.LINE_LENGTH(LINE_LENGTH)) u_back (
    .clk_i,
    .rst_ni,
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_desc_i   (pop_desc),
    .out_valid_o,
    .out_ready_i,
    .register_select_o,
    .code_byte_o,
    .nibble_only_o,
    .last_of_run_o
  );

endmodule

`default_nettype wire

[sv/clw_checker.sv]
// ----------------------------------------------------------------------------
// clw_checker
// Port-level checks for the display write sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_write_sequencer_macros.svh"

module clw_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       register_select_o,
  input wire logic [7:0] code_byte_o,
  input wire logic       nibble_only_o,
  input wire logic       last_of_run_o
);

  // a stalled transfer keeps its byte
  `CLW_ASSERT(a_out_hold,
              out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_byte_o)
              && $stable(register_select_o) && $stable(last_of_run_o),
              "output changed while stalled")

  // wake-up nibbles are commands with an empty high nibble
  `CLW_ASSERT(a_nib_cmd,
              out_valid_o && nibble_only_o |-> !register_select_o
              && code_byte_o[7:4] == 4'h0,
              "bad nibble-only byte")

  // the init run never ends on a wake-up nibble
  `CLW_ASSERT(a_nib_not_last, out_valid_o && nibble_only_o |-> !last_of_run_o,
              "run ended on a nibble-only byte")

  // a reset edge leaves the output idle
  `CLW_ASSERT_RST(a_rst_idle, !rst_ni |=> !out_valid_o, "output valid after reset")

endmodule

bind char_lcd_write_sequencer clw_checker u_clw_checker (.*);

`default_nettype wire
